// ===== src/json_string_unescape_core_macros.svh =====
// Assertion macros shared by the string unescaper RTL.
`ifndef JSON_STRING_UNESCAPE_CORE_MACROS_SVH
`define JSON_STRING_UNESCAPE_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define JSU_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define JSU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/jsu_pkg.sv =====
// Types, codes and helper functions for the JSON string unescaper.
package jsu_pkg;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_ESCAPE = 3'd1,
    MODE_HEX0   = 3'd2,
    MODE_HEX1   = 3'd3,
    MODE_HEX2   = 3'd4,
    MODE_HEX3   = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    ST_DATA          = 3'd0,
    ST_CLOSED        = 3'd1,
    ST_BAD_ESCAPE    = 3'd2,
    ST_BAD_HEX       = 3'd3,
    ST_UNTERMINATED  = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] out_byte;
    status_t    status;
    logic       last;
  } result_t;

  // Everything one input byte produces: up to three results, first in slot 0.
  typedef struct packed {
    logic [1:0]        count;
    result_t [2:0]     res;
  } dec_out_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam logic [7:0] CTL_BS = 8'h08;
  localparam logic [7:0] CTL_FF = 8'h0c;
  localparam logic [7:0] CTL_LF = 8'h0a;
  localparam logic [7:0] CTL_CR = 8'h0d;
  localparam logic [7:0] CTL_HT = 8'h09;

  localparam logic [15:0] UTF8_ONE_LIMIT = 16'h0080;
  localparam logic [15:0] UTF8_TWO_LIMIT = 16'h0800;
  localparam logic [7:0]  UTF8_CONT      = 8'h80;
  localparam logic [7:0]  UTF8_LEAD2     = 8'hc0;
  localparam logic [7:0]  UTF8_LEAD3     = 8'he0;
  localparam logic [15:0] UTF8_CONT_MASK = 16'h003f;

  // Bit 4 flags a valid hex digit, bits 3:0 carry its value.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  function automatic result_t mk_result(input logic [7:0] b, input status_t s,
                                        input logic l);
    result_t r;
    r.out_byte = b;
    r.status   = s;
    r.last     = l;
    return r;
  endfunction

endpackage

// ===== src/jsu_in_if.sv =====
// Valid/ready channel that carries raw string body bytes.
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// ===== src/jsu_out_if.sv =====
// Valid/ready channel that carries decoded bytes and their status.
interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] status;
  logic       last;

  modport source (output valid, output out_byte, output status, output last, input ready);
  modport sink   (input valid, input out_byte, input status, input last, output ready);
endinterface

// ===== src/jsu_decode.sv =====
// Combinational decode of one byte against the escape state.
module jsu_decode import jsu_pkg::*; (
  input  mode_t       mode,
  input  logic [15:0] acc,
  input  logic [7:0]  in_byte,
  output mode_t       mode_next,
  output logic [15:0] acc_next,
  output dec_out_t    dec
);

  logic [4:0]  hexv;
  logic [15:0] unit;

  assign hexv = hex_decode(in_byte);
  assign unit = {acc[11:0], hexv[3:0]};

  always_comb begin
    mode_next = mode;
    acc_next  = acc;
    dec       = '0;
    unique case (mode)
      MODE_ESCAPE: begin
        mode_next = MODE_NORMAL;
        dec.count = 2'd1;
        unique case (in_byte)
          CH_QUOTE, CH_BSLASH, CH_SLASH: dec.res[0] = mk_result(in_byte, ST_DATA, 1'b1);
          CH_B: dec.res[0] = mk_result(CTL_BS, ST_DATA, 1'b1);
          CH_F: dec.res[0] = mk_result(CTL_FF, ST_DATA, 1'b1);
          CH_N: dec.res[0] = mk_result(CTL_LF, ST_DATA, 1'b1);
          CH_R: dec.res[0] = mk_result(CTL_CR, ST_DATA, 1'b1);
          CH_T: dec.res[0] = mk_result(CTL_HT, ST_DATA, 1'b1);
          CH_U: begin
            mode_next = MODE_HEX0;
            acc_next  = '0;
            dec.count = 2'd0;
          end
          default: dec.res[0] = mk_result(8'h00, ST_BAD_ESCAPE, 1'b1);
        endcase
      end
      MODE_HEX0, MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
        if (!hexv[4]) begin
          mode_next  = MODE_NORMAL;
          acc_next   = '0;
          dec.count  = 2'd1;
          dec.res[0] = mk_result(8'h00, ST_BAD_HEX, 1'b1);
        end else begin
          acc_next = unit;
          if (mode == MODE_HEX3) begin
            mode_next = MODE_NORMAL;
            if (unit < UTF8_ONE_LIMIT) begin
              dec.count  = 2'd1;
              dec.res[0] = mk_result(unit[7:0], ST_DATA, 1'b1);
            end else if (unit < UTF8_TWO_LIMIT) begin
              dec.count  = 2'd2;
              dec.res[0] = mk_result(UTF8_LEAD2 | 8'(unit >> 6), ST_DATA, 1'b0);
              dec.res[1] = mk_result(UTF8_CONT | 8'(unit & UTF8_CONT_MASK), ST_DATA, 1'b1);
            end else begin
              dec.count  = 2'd3;
              dec.res[0] = mk_result(UTF8_LEAD3 | 8'(unit >> 12), ST_DATA, 1'b0);
              dec.res[1] = mk_result(UTF8_CONT | 8'((unit >> 6) & UTF8_CONT_MASK),
                                     ST_DATA, 1'b0);
              dec.res[2] = mk_result(UTF8_CONT | 8'(unit & UTF8_CONT_MASK), ST_DATA, 1'b1);
            end
          end else begin
            mode_next = mode_t'(3'(mode + 3'd1));
          end
        end
      end
      default: begin
        // Normal mode; unused codes behave the same way.
        mode_next = MODE_NORMAL;
        dec.count = 2'd1;
        priority if (in_byte == CH_NUL) begin
          dec.res[0] = mk_result(8'h00, ST_UNTERMINATED, 1'b1);
        end else if (in_byte == CH_QUOTE) begin
          dec.res[0] = mk_result(8'h00, ST_CLOSED, 1'b1);
        end else if (in_byte == CH_BSLASH) begin
          mode_next = MODE_ESCAPE;
          dec.count = 2'd0;
        end else begin
          dec.res[0] = mk_result(in_byte, ST_DATA, 1'b1);
        end
      end
    endcase
  end

endmodule

// ===== src/jsu_outbuf.sv =====
// Result register that holds up to three results and hands them out in order.
module jsu_outbuf import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  dec_out_t   load_data,
  input  logic       pop,
  output logic       can_load,
  output logic       head_valid,
  output result_t    head,
  output logic [1:0] cnt
);

  result_t r0, r1, r2;

  assign head_valid = (cnt != 2'd0);
  assign head       = r0;
  // A new set may land once the last pending result leaves this cycle.
  assign can_load   = (cnt == 2'd0) || (cnt == 2'd1 && pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= load_data.count;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      r0 <= load_data.res[0];
      r1 <= load_data.res[1];
      r2 <= load_data.res[2];
    end else if (pop) begin
      r0 <= r1;
      r1 <= r2;
    end
  end

endmodule

// ===== src/json_string_unescape_core.sv =====
// A taken byte passes the input register, then the result register, before results show.
// Throughput: one byte per cycle if each yields at most one result and output is ready.
// A \u escape that expands to two or three UTF-8 bytes holds the input back while
// the single output register drains them, one a cycle when the output is ready.
// Reset (rst, synchronous, active high) returns to normal mode and empties all stages.
`include "json_string_unescape_core_macros.svh"

module json_string_unescape_core import jsu_pkg::*; (
  input logic       clk,
  input logic       rst,
  jsu_in_if.sink    raw,
  jsu_out_if.source decoded
);

  // Input register: one raw byte waiting to be decoded.
  logic       s1_valid;
  logic [7:0] s1_byte;

  // Escape state carried from byte to byte.
  mode_t       mode;
  mode_t       mode_next;
  logic [15:0] acc;
  logic [15:0] acc_next;

  dec_out_t   dec;
  logic       s1_move;
  logic       buf_can_load;
  logic       buf_pop;
  logic       head_valid;
  result_t    head;
  logic [1:0] buf_cnt;

  // The registered byte moves into the result register as soon as that register
  // will be free; the input side takes a new byte in the same cycle, so a stalled
  // output holds the captured byte in the input register and stops new bytes.
  assign s1_move   = s1_valid && buf_can_load;
  assign raw.ready = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (raw.ready) begin
      s1_valid <= raw.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (raw.valid && raw.ready) begin
      s1_byte <= raw.in_byte;
    end
  end

  // The escape state advances only when a byte is actually decoded.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NORMAL;
      acc  <= '0;
    end else if (s1_move) begin
      mode <= mode_next;
      acc  <= acc_next;
    end
  end

  jsu_decode u_decode (
    .mode      (mode),
    .acc       (acc),
    .in_byte   (s1_byte),
    .mode_next (mode_next),
    .acc_next  (acc_next),
    .dec       (dec)
  );

  assign buf_pop = decoded.valid && decoded.ready;

  jsu_outbuf u_outbuf (
    .clk        (clk),
    .rst        (rst),
    .load       (s1_move),
    .load_data  (dec),
    .pop        (buf_pop),
    .can_load   (buf_can_load),
    .head_valid (head_valid),
    .head       (head),
    .cnt        (buf_cnt)
  );

  assign decoded.valid    = head_valid;
  assign decoded.out_byte = head.out_byte;
  assign decoded.status   = head.status;
  assign decoded.last     = head.last;

  // A result that is not the last of its byte always has a successor queued.
  `JSU_ASSERT_SAME(a_not_last_has_more, clk, rst, decoded.valid && !decoded.last,
    buf_cnt >= 2'd2, "non-final result shown with no follower queued")
  // A three-byte expansion keeps the output busy on the following cycle.
  `JSU_ASSERT_NEXT(a_three_byte_held, clk, rst, s1_move && dec.count == 2'd3,
    decoded.valid && buf_cnt != 2'd0, "three-byte UTF-8 expansion lost")
  // After a backslash the next decoded byte ends in normal or hex-gather mode.
  `JSU_ASSERT_NEXT(a_escape_exit, clk, rst, s1_move && mode == MODE_ESCAPE,
    mode == MODE_NORMAL || mode == MODE_HEX0, "bad mode after escape letter")
  // A byte that yields results never overwrites results still waiting.
  `JSU_ASSERT_SAME(a_no_overwrite, clk, rst, s1_move && buf_cnt != 2'd0,
    buf_cnt == 2'd1 && buf_pop, "result register overwritten while busy")

endmodule
